@@ src/prm_pkg.sv @@
// Shared constants and helpers for the pulse rate monitor.
// No dependencies; used by pulse_rate_monitor_with_alarm.
package prm_pkg;

    localparam int unsigned TICKS_PER_SECOND = 100;
    localparam int unsigned HISTORY_DEPTH    = 3;

    localparam int unsigned TICK_W  = 7;
    localparam int unsigned SEC_W   = 6;
    localparam int unsigned MIN_W   = 6;
    localparam int unsigned HOUR_W  = 5;
    localparam int unsigned COUNT_W = 8;
    localparam int unsigned RATE_W  = 12;
    localparam int unsigned SLOT_W  = 2;
    localparam int unsigned SUM_W   = 14;

    localparam logic [SEC_W-1:0]  SECS_PER_MIN  = 6'd60;
    localparam logic [MIN_W-1:0]  MINS_PER_HOUR = 6'd60;
    localparam logic [HOUR_W-1:0] HOURS_PER_DAY = 5'd24;

    localparam logic [SEC_W-1:0] FILL_BOTH_SEC = 6'd5;
    localparam logic [SEC_W-1:0] FILL_LAST_SEC = 6'd10;

    localparam logic [COUNT_W-1:0] COUNT_MAX      = 8'd255;
    localparam logic [COUNT_W-1:0] COUNT_ADJ_OVER = 8'd8;

    // Register indexes on the configuration port (byte address / 4)
    localparam logic [0:0] REG_MIN_BOUND = 1'b0;
    localparam logic [0:0] REG_MAX_BOUND = 1'b1;

    localparam logic [RATE_W-1:0] MIN_BOUND_RESET = 12'd30;
    localparam logic [RATE_W-1:0] MAX_BOUND_RESET = 12'd120;

    // floor(v/3) for v < 2^14 as (v * 21846) >> 16
    localparam logic [14:0] DIV3_RECIP = 15'd21846;
    localparam int unsigned DIV3_SHIFT = 16;

    // Seconds value is a multiple of five (0..59 range)
    function automatic logic is_report_second(input logic [SEC_W-1:0] sec);
        logic hit;
        case (sec) inside
            6'd0, 6'd5, 6'd10, 6'd15, 6'd20, 6'd25,
            6'd30, 6'd35, 6'd40, 6'd45, 6'd50, 6'd55: hit = 1'b1;
            default:                                 hit = 1'b0;
        endcase
        return hit;
    endfunction

    function automatic logic [RATE_W-1:0] div3(input logic [SUM_W-1:0] v);
        logic [SUM_W+15-1:0] prod;
        prod = (SUM_W+15)'(v) * (SUM_W+15)'(DIV3_RECIP);
        return prod[DIV3_SHIFT +: RATE_W];
    endfunction

endpackage

@@ src/pulse_rate_monitor_with_alarm.sv @@
// Pulse rate monitor top level: sample stream in, status stream out, APB config.
// Depends on prm_pkg (constants, seconds decode, divide-by-three helper).
//
// Usage
// - Input stream s_axis: one request per pulse-line sample. tdata[0] is the
//   sampled pulse level, tdata[1] flags a 10 ms timebase tick with the sample.
// - Output stream m_axis: exactly one result per accepted sample, in order.
//   It carries the LED, both alarms, a report strobe with the averaged BPM
//   (zero when no report) and the hours/minutes/seconds clock.
// - Latency: the result of a sample is presented on the cycle after it is
//   accepted. Throughput: one sample per cycle while m_axis is not stalled,
//   with a single update pass over the clock, edge counter and three-slot history.
// - Stall: s_axis_tready follows the output register; while a result waits
//   and m_axis_tready is low, no new sample is taken and state holds.
//   When the result is taken, the next sample is accepted in the same cycle.
// - Reset (synchronous, active low): clock, counters, history, alarms and
//   the output valid flag clear; min_bound returns to 30, max_bound to 120.
// - Config: registers min_bound at byte address 0, max_bound at 4. Write
//   only while idle. pready is tied high; reads return the 12-bit value.
module pulse_rate_monitor_with_alarm (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // sample stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [0] pulse_level, [1] tick, [7:2] zero
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [0] pulse_led, [1] alarm_low, [2] alarm_high,
                                        // [3] report_valid, [15:4] average_bpm,
                                        // [20:16] clock_hours, [26:21] clock_minutes,
                                        // [32:27] clock_seconds, [39:33] zero
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned TICK_W  = prm_pkg::TICK_W;
    localparam int unsigned SEC_W   = prm_pkg::SEC_W;
    localparam int unsigned MIN_W   = prm_pkg::MIN_W;
    localparam int unsigned HOUR_W  = prm_pkg::HOUR_W;
    localparam int unsigned COUNT_W = prm_pkg::COUNT_W;
    localparam int unsigned RATE_W  = prm_pkg::RATE_W;
    localparam int unsigned SLOT_W  = prm_pkg::SLOT_W;
    localparam int unsigned SUM_W   = prm_pkg::SUM_W;
    localparam int unsigned DEPTH   = prm_pkg::HISTORY_DEPTH;

    localparam logic [TICK_W-1:0] TICK_WRAP = TICK_W'(prm_pkg::TICKS_PER_SECOND);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(DEPTH - 1);

    // ---------------- configuration registers ----------------
    logic [RATE_W-1:0] r_min_bound;
    logic [RATE_W-1:0] r_max_bound;
    logic              cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_bound <= prm_pkg::MIN_BOUND_RESET;
            r_max_bound <= prm_pkg::MAX_BOUND_RESET;
        end else if (cfg_write) begin
            unique case (paddr[2])
                prm_pkg::REG_MIN_BOUND: r_min_bound <= pwdata[RATE_W-1:0];
                prm_pkg::REG_MAX_BOUND: r_max_bound <= pwdata[RATE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            prm_pkg::REG_MIN_BOUND: prdata = 32'(r_min_bound);
            prm_pkg::REG_MAX_BOUND: prdata = 32'(r_max_bound);
            default:                prdata = '0;
        endcase
    end

    // ---------------- monitor state ----------------
    logic [TICK_W-1:0]  r_tick_count,  n_tick_count;
    logic [SEC_W-1:0]   r_sec_count,   n_sec_count;
    logic [MIN_W-1:0]   r_min_count,   n_min_count;
    logic [HOUR_W-1:0]  r_hour_count,  n_hour_count;
    logic               r_report_armed, n_report_armed;
    logic               r_prev_level,  n_prev_level;
    logic [COUNT_W-1:0] r_edge_count,  n_edge_count;
    logic [RATE_W-1:0]  r_hist [DEPTH];
    logic [RATE_W-1:0]  n_hist [DEPTH];
    logic [SLOT_W-1:0]  r_hist_slot,   n_hist_slot;
    logic               r_low_flag,    n_low_flag;
    logic               r_high_flag,   n_high_flag;

    // output register
    logic               r_out_valid;
    logic               r_out_led;
    logic               r_out_low;
    logic               r_out_high;
    logic               r_out_report;
    logic [SUM_W-1:0]   r_out_sum;
    logic [HOUR_W-1:0]  r_out_hours;
    logic [MIN_W-1:0]   r_out_minutes;
    logic [SEC_W-1:0]   r_out_seconds;

    logic               in_accept;
    logic               level;
    logic               tick;
    logic               fall;
    logic               report;
    logic [COUNT_W-1:0] count_adj;
    logic [COUNT_W-1:0] count_base;
    logic [RATE_W-1:0]  rate;
    logic [SLOT_W-1:0]  slot;
    logic [SUM_W-1:0]   n_sum;

    // take a new sample whenever the output register is free or draining
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign level         = s_axis_tdata[0];
    assign tick          = s_axis_tdata[1];

    always_comb begin
        n_tick_count   = r_tick_count;
        n_sec_count    = r_sec_count;
        n_min_count    = r_min_count;
        n_hour_count   = r_hour_count;
        n_report_armed = r_report_armed;
        n_edge_count   = r_edge_count;
        n_hist         = r_hist;
        n_hist_slot    = r_hist_slot;
        n_low_flag     = r_low_flag;
        n_high_flag    = r_high_flag;
        n_prev_level   = level;
        n_sum          = '0;

        // advance the clock first; an edge in the same sample sees the result
        if (tick) begin
            n_tick_count = r_tick_count + TICK_W'(1);
            if (n_tick_count == TICK_WRAP) begin
                n_sec_count  = r_sec_count + SEC_W'(1);
                n_tick_count = '0;
            end
            if (n_sec_count == prm_pkg::SECS_PER_MIN) begin
                n_sec_count = '0;
                n_min_count = r_min_count + MIN_W'(1);
            end
            if (n_min_count == prm_pkg::MINS_PER_HOUR) begin
                n_min_count  = '0;
                n_hour_count = r_hour_count + HOUR_W'(1);
            end
            if (n_hour_count == prm_pkg::HOURS_PER_DAY) begin
                n_hour_count = '0;
            end
            if (prm_pkg::is_report_second(n_sec_count) && n_tick_count == '0) begin
                n_report_armed = 1'b1;
            end
        end

        // count falling edges, saturating
        fall = r_prev_level && !level;
        if (fall && r_edge_count != prm_pkg::COUNT_MAX) begin
            n_edge_count = r_edge_count + COUNT_W'(1);
        end
        report = fall && n_report_armed;

        // rate = (count - 1) * 12, one off first for counts above eight
        count_adj  = (n_edge_count > prm_pkg::COUNT_ADJ_OVER) ?
                     n_edge_count - COUNT_W'(1) : n_edge_count;
        count_base = count_adj - COUNT_W'(1);
        rate       = {1'b0, count_base, 3'b000} + {2'b00, count_base, 2'b00};
        slot       = (r_hist_slot > SLOT_LAST) ? '0 : r_hist_slot;

        if (report) begin
            n_hist[slot] = rate;

            if (rate < r_min_bound) begin
                n_low_flag = 1'b1;
            end else if (rate > r_max_bound) begin
                n_high_flag = 1'b1;
            end else if (r_low_flag) begin
                n_low_flag = 1'b0;
            end else if (r_high_flag) begin
                n_high_flag = 1'b0;
            end

            // seed the empty slots early in the run
            if (n_sec_count == prm_pkg::FILL_BOTH_SEC &&
                n_hist[1] == '0 && n_hist[2] == '0) begin
                n_hist[1] = rate;
                n_hist[2] = rate;
            end else if (n_sec_count == prm_pkg::FILL_LAST_SEC && n_hist[2] == '0) begin
                n_hist[2] = rate;
            end

            n_edge_count   = '0;
            n_report_armed = 1'b0;
            n_hist_slot    = (slot == SLOT_LAST) ? '0 : slot + SLOT_W'(1);
            n_sum          = SUM_W'(n_hist[0]) + SUM_W'(n_hist[1]) + SUM_W'(n_hist[2]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_count   <= '0;
            r_sec_count    <= '0;
            r_min_count    <= '0;
            r_hour_count   <= '0;
            r_report_armed <= 1'b0;
            r_prev_level   <= 1'b0;
            r_edge_count   <= '0;
            for (int k = 0; k < DEPTH; k++) begin
                r_hist[k] <= '0;
            end
            r_hist_slot    <= '0;
            r_low_flag     <= 1'b0;
            r_high_flag    <= 1'b0;
        end else if (in_accept) begin
            r_tick_count   <= n_tick_count;
            r_sec_count    <= n_sec_count;
            r_min_count    <= n_min_count;
            r_hour_count   <= n_hour_count;
            r_report_armed <= n_report_armed;
            r_prev_level   <= n_prev_level;
            r_edge_count   <= n_edge_count;
            r_hist         <= n_hist;
            r_hist_slot    <= n_hist_slot;
            r_low_flag     <= n_low_flag;
            r_high_flag    <= n_high_flag;
        end
    end

    // result register: load on accept, drop valid once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_led     <= level;
            r_out_low     <= n_low_flag;
            r_out_high    <= n_high_flag;
            r_out_report  <= report;
            r_out_sum     <= n_sum;
            r_out_hours   <= n_hour_count;
            r_out_minutes <= n_min_count;
            r_out_seconds <= n_sec_count;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out_seconds, r_out_minutes, r_out_hours,
                            prm_pkg::div3(r_out_sum), r_out_report,
                            r_out_high, r_out_low, r_out_led};

`ifndef ASSERT_OFF
    a_tick_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tick_count < TICK_WRAP)
        else $error("tick counter past one second");

    a_clock_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sec_count < prm_pkg::SECS_PER_MIN && r_min_count < prm_pkg::MINS_PER_HOUR &&
        r_hour_count < prm_pkg::HOURS_PER_DAY)
        else $error("clock field out of range");

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hist_slot <= SLOT_LAST)
        else $error("history slot out of range");

    a_report_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && report |=> r_edge_count == '0 && !r_report_armed && r_out_report)
        else $error("report did not clear count and arm");

    a_avg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_report |-> r_out_sum == '0)
        else $error("average present without report");
`endif

endmodule
